FILE: hw/rtl/ptc_pkg.sv
// ---------------------------------------------------------------------------
// ptc_pkg: shared types and constants of the preprocessor token classifier
// Token kind codes and the directive keyword table.
// ---------------------------------------------------------------------------
package ptc_pkg;

  // Keyword table geometry
  localparam int MAX_KEYWORD_LEN = 7;
  localparam int KW_COUNT        = 13;
  localparam int KW_TEXT_LEN     = 7;
  localparam int HEAD_DEPTH      = 3;
  localparam int COUNT_W         = 4;

  localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

  // Token kinds, densely numbered
  typedef enum logic [5:0] {
    KIND_RAW_CHAR     = 6'd0,
    KIND_WHITESPACE   = 6'd1,
    KIND_CHARLIT      = 6'd2,
    KIND_STRLIT       = 6'd3,
    KIND_NUMBER       = 6'd4,
    KIND_PREPROC      = 6'd5,
    KIND_LINECOMMENT  = 6'd6,
    KIND_BLOCKCOMMENT = 6'd7,
    KIND_IDENT        = 6'd8,
    KIND_DEFINED      = 6'd9,
    KIND_SCOPE        = 6'd10,
    KIND_ASSIGN       = 6'd11,
    KIND_EQ           = 6'd12,
    KIND_NOT_EQ       = 6'd13,
    KIND_AND          = 6'd14,
    KIND_OR           = 6'd15,
    KIND_INCR         = 6'd16,
    KIND_LEFT_SHIFT   = 6'd17,
    KIND_LEQ          = 6'd18,
    KIND_RIGHT_SHIFT  = 6'd19,
    KIND_GEQ          = 6'd20,
    KIND_PTRMEM       = 6'd21,
    KIND_ARROW        = 6'd22,
    KIND_DECR         = 6'd23,
    KIND_ELLIPSIS     = 6'd24,
    KIND_IF           = 6'd25,
    KIND_ELIF         = 6'd26,
    KIND_ELSE         = 6'd27,
    KIND_LINE         = 6'd28,
    KIND_ENDIF        = 6'd29,
    KIND_IFDEF        = 6'd30,
    KIND_ERROR        = 6'd31,
    KIND_UNDEF        = 6'd32,
    KIND_PRAGMA       = 6'd33,
    KIND_IFNDEF       = 6'd34,
    KIND_DEFINE       = 6'd35,
    KIND_INCLUDE      = 6'd36
  } kind_t;

  typedef logic [KW_COUNT-1:0] kw_mask_t;

  localparam kw_mask_t KW_ALL_ALIVE = '1;

  // Keyword spelling, zero padded
  localparam logic [7:0] KW_TEXT [KW_COUNT][KW_TEXT_LEN] = '{
    '{"i", "f", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
    '{"e", "l", "i", "f", 8'h00, 8'h00, 8'h00},
    '{"e", "l", "s", "e", 8'h00, 8'h00, 8'h00},
    '{"l", "i", "n", "e", 8'h00, 8'h00, 8'h00},
    '{"e", "n", "d", "i", "f", 8'h00, 8'h00},
    '{"i", "f", "d", "e", "f", 8'h00, 8'h00},
    '{"e", "r", "r", "o", "r", 8'h00, 8'h00},
    '{"u", "n", "d", "e", "f", 8'h00, 8'h00},
    '{"p", "r", "a", "g", "m", "a", 8'h00},
    '{"i", "f", "n", "d", "e", "f", 8'h00},
    '{"d", "e", "f", "i", "n", "e", 8'h00},
    '{"i", "n", "c", "l", "u", "d", "e"},
    '{"d", "e", "f", "i", "n", "e", "d"}
  };

  localparam logic [COUNT_W-1:0] KW_LEN [KW_COUNT] = '{
    4'd2, 4'd4, 4'd4, 4'd4, 4'd5, 4'd5, 4'd5, 4'd5, 4'd6, 4'd6, 4'd6, 4'd7, 4'd7
  };

  localparam kind_t KW_KIND [KW_COUNT] = '{
    KIND_IF, KIND_ELIF, KIND_ELSE, KIND_LINE, KIND_ENDIF, KIND_IFDEF, KIND_ERROR,
    KIND_UNDEF, KIND_PRAGMA, KIND_IFNDEF, KIND_DEFINE, KIND_INCLUDE, KIND_DEFINED
  };

endpackage

FILE: hw/rtl/preprocessor_token_classifier.sv
// ---------------------------------------------------------------------------
// preprocessor_token_classifier: token kind from the bytes of one token
// Tracks head bytes, length and keyword matches; emits one kind per token.
// ---------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready, ch, last) carries one token byte per
//   transaction, first byte first; last marks the token's final byte.
//   Output channel (out_valid/out_ready, token_kind, raw_code) carries one
//   transaction per token, raised by the byte with last set.
//   The result is registered and visible in the cycle after the final byte
//   is taken. Throughput: one byte per cycle while in_ready is high, set by
//   the per-byte update that feeds the state and result registers.
//   A byte is taken whenever the result register is empty or is being
//   drained in the same cycle, so a stalled receiver holds the input off
//   only while a finished result waits.
//   Reset clears the head bytes and byte count, marks every keyword as
//   still matching and empties the result register; the head bytes, count
//   and keyword matches are cleared the same way after each final byte.
// ---------------------------------------------------------------------------
module preprocessor_token_classifier (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] ch,
  input  logic       last,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [5:0] token_kind,
  output logic [7:0] raw_code
);

  // Per-token state
  logic [7:0]                  head [ptc_pkg::HEAD_DEPTH];
  logic [ptc_pkg::COUNT_W-1:0] byte_count;
  ptc_pkg::kw_mask_t           keyword_alive;

  logic [7:0]                  head_next [ptc_pkg::HEAD_DEPTH];
  logic [ptc_pkg::COUNT_W-1:0] count_next;
  ptc_pkg::kw_mask_t           alive_next;

  ptc_pkg::kind_t kind_next;
  logic [7:0]     raw_next;
  logic           in_fire;

  // Operator rules with two lookahead bytes
  function automatic ptc_pkg::kind_t op_kind(input logic [7:0] a, input logic [7:0] b,
                                             input logic [7:0] c);
    ptc_pkg::kind_t k;
    k = ptc_pkg::KIND_RAW_CHAR;
    priority if (a == ":") begin
      if (b == ":") k = ptc_pkg::KIND_SCOPE;
    end else if (a == "*" || a == "/" || a == "%" || a == "^") begin
      if (b == "=") k = ptc_pkg::KIND_ASSIGN;
    end else if (a == "=") begin
      if (b == "=") k = ptc_pkg::KIND_EQ;
    end else if (a == "!") begin
      if (b == "=") k = ptc_pkg::KIND_NOT_EQ;
    end else if (a == "&") begin
      if (b == "&") k = ptc_pkg::KIND_AND;
      else if (b == "=") k = ptc_pkg::KIND_ASSIGN;
    end else if (a == "|") begin
      if (b == "|") k = ptc_pkg::KIND_OR;
      else if (b == "=") k = ptc_pkg::KIND_ASSIGN;
    end else if (a == "+") begin
      if (b == "+") k = ptc_pkg::KIND_INCR;
      else if (b == "=") k = ptc_pkg::KIND_ASSIGN;
    end else if (a == "<") begin
      if (b == "<") k = (c == "=") ? ptc_pkg::KIND_ASSIGN : ptc_pkg::KIND_LEFT_SHIFT;
      else if (b == "=") k = ptc_pkg::KIND_LEQ;
    end else if (a == ">") begin
      if (b == ">") k = (c == "=") ? ptc_pkg::KIND_ASSIGN : ptc_pkg::KIND_RIGHT_SHIFT;
      else if (b == "=") k = ptc_pkg::KIND_GEQ;
    end else if (a == "-") begin
      if (b == ">") k = (c == "*") ? ptc_pkg::KIND_PTRMEM : ptc_pkg::KIND_ARROW;
      else if (b == "-") k = ptc_pkg::KIND_DECR;
      else if (b == "=") k = ptc_pkg::KIND_ASSIGN;
    end else if (a == ".") begin
      if (b == "." && c == ".") k = ptc_pkg::KIND_ELLIPSIS;
      else if (b == "*") k = ptc_pkg::KIND_PTRMEM;
    end else begin
      k = ptc_pkg::KIND_RAW_CHAR;
    end
    return k;
  endfunction

  assign in_ready = !out_valid || out_ready;
  assign in_fire  = in_valid && in_ready;

  // State update for the incoming byte
  always_comb begin
    for (int i = 0; i < ptc_pkg::HEAD_DEPTH; i++) begin
      head_next[i] = (byte_count == ptc_pkg::COUNT_W'(i)) ? ch : head[i];
    end
    for (int k = 0; k < ptc_pkg::KW_COUNT; k++) begin
      alive_next[k] = keyword_alive[k]
                   && (byte_count < ptc_pkg::KW_LEN[k])
                   && (byte_count < ptc_pkg::COUNT_W'(ptc_pkg::MAX_KEYWORD_LEN))
                   && (ptc_pkg::KW_TEXT[k][byte_count[2:0]] == ch);
    end
    count_next = (byte_count == ptc_pkg::COUNT_MAX) ? byte_count
                                                     : byte_count + 1'b1;
  end

  // Classification on the updated state
  always_comb begin
    logic [7:0] a;
    logic       hit;
    a         = head_next[0];
    hit       = 1'b0;
    kind_next = ptc_pkg::KIND_IDENT;
    priority if (a == " " || a == "\t" || a == 8'h0B || a == 8'h0C || a == 8'h0D) begin
      kind_next = ptc_pkg::KIND_WHITESPACE;
    end else if (a == "'") begin
      kind_next = ptc_pkg::KIND_CHARLIT;
    end else if (a == "\"") begin
      kind_next = ptc_pkg::KIND_STRLIT;
    end else if (a >= "0" && a <= "9") begin
      kind_next = ptc_pkg::KIND_NUMBER;
    end else if (a == "#") begin
      kind_next = ptc_pkg::KIND_PREPROC;
    end else if ((a >= "a" && a <= "z") || (a >= "A" && a <= "Z") || a == "_") begin
      // first surviving keyword of the exact length wins
      for (int k = 0; k < ptc_pkg::KW_COUNT; k++) begin
        if (!hit && alive_next[k] && ptc_pkg::KW_LEN[k] == count_next) begin
          hit       = 1'b1;
          kind_next = ptc_pkg::KW_KIND[k];
        end
      end
    end else if (a == "/" && head_next[1] == "/") begin
      kind_next = ptc_pkg::KIND_LINECOMMENT;
    end else if (a == "/" && head_next[1] == "*") begin
      kind_next = ptc_pkg::KIND_BLOCKCOMMENT;
    end else begin
      kind_next = op_kind(a, head_next[1], head_next[2]);
    end
    raw_next = (kind_next == ptc_pkg::KIND_RAW_CHAR) ? a : 8'h00;
  end

  // Per-token state registers; cleared after each final byte
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < ptc_pkg::HEAD_DEPTH; i++) head[i] <= 8'h00;
      byte_count    <= '0;
      keyword_alive <= ptc_pkg::KW_ALL_ALIVE;
    end else if (in_fire) begin
      if (last) begin
        for (int i = 0; i < ptc_pkg::HEAD_DEPTH; i++) head[i] <= 8'h00;
        byte_count    <= '0;
        keyword_alive <= ptc_pkg::KW_ALL_ALIVE;
      end else begin
        head          <= head_next;
        byte_count    <= count_next;
        keyword_alive <= alive_next;
      end
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_fire && last) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire && last) begin
      token_kind <= kind_next;
      raw_code   <= raw_next;
    end
  end

endmodule
